>>> rtl/idb_pkg.sv
// ----------------------------------------------------------------------------
// Debouncer bank package
// Shared types and constants for the integrating debouncer bank.
// ----------------------------------------------------------------------------
package idb_pkg;

    // Bank geometry and field widths
    localparam int MAX_CHANNELS = 15;
    localparam int OP_W         = 2;
    localparam int CH_IDX_W     = 4;
    localparam int THRESH_W     = 8;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd20;

    // Operation codes
    localparam logic [OP_W-1:0] OP_TICK = 2'd0;
    localparam logic [OP_W-1:0] OP_READ = 2'd1;
    localparam logic [OP_W-1:0] OP_LOAD = 2'd2;

    // Input word
    typedef struct packed {
        logic [OP_W-1:0]         operation;
        logic [MAX_CHANNELS-1:0] raw_levels;
        logic [CH_IDX_W-1:0]     channel;
    } in_word_t;

    // Output word
    typedef struct packed {
        logic [MAX_CHANNELS-1:0] stable_levels;
        logic [MAX_CHANNELS-1:0] pending_events;
        logic                    read_level;
        logic                    read_event;
    } out_word_t;

    // Controls shared by every lane for one accepted word
    typedef struct packed {
        logic tick;
        logic load;
    } lane_ctrl_t;

endpackage

>>> rtl/idb_lane.sv
// ----------------------------------------------------------------------------
// Debouncer lane
// One channel: integrating counter, debounced level and sticky event flag.
// ----------------------------------------------------------------------------
module idb_lane
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  idb_pkg::lane_ctrl_t           ctrl,
    input  logic                          read_clr,
    input  logic                          raw_bit,
    input  logic [idb_pkg::THRESH_W-1:0]  threshold,
    output logic                          level,
    output logic                          event_flag,
    output logic                          level_next,
    output logic                          event_next
);
    import idb_pkg::*;

    logic [THRESH_W-1:0] count_reg;
    logic [THRESH_W-1:0] count_next;
    logic [THRESH_W-1:0] count_up;
    logic                level_reg;
    logic                event_reg;

    // Saturating up count toward the threshold
    assign count_up = (count_reg < threshold) ? count_reg + 1'b1 : count_reg;

    // Next-state logic for tick, load and read-clear
    always_comb
    begin
        count_next = count_reg;
        level_next = level_reg;
        event_next = event_reg;
        if (ctrl.load)
        begin
            count_next = '0;
            level_next = raw_bit;
            event_next = 1'b0;
        end
        else if (ctrl.tick)
        begin
            if (raw_bit == level_reg)
            begin
                if (count_reg != '0)
                    count_next = count_reg - 1'b1;
            end
            else if (count_up >= threshold)
            begin
                // Settled: take the new level, rising edge raises the flag
                count_next = '0;
                level_next = raw_bit;
                event_next = event_reg | raw_bit;
            end
            else
            begin
                count_next = count_up;
            end
        end
        else if (read_clr)
        begin
            event_next = 1'b0;
        end
    end

    // Lane state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            level_reg <= 1'b0;
            event_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            level_reg <= level_next;
            event_reg <= event_next;
        end
    end

    assign level      = level_reg;
    assign event_flag = event_reg;

endmodule

>>> rtl/idb_merge.sv
// ----------------------------------------------------------------------------
// Debouncer result merge
// Gathers lane results into one word and holds it in the output register.
// ----------------------------------------------------------------------------
module idb_merge
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               capture,
    input  logic                               is_read,
    input  logic [idb_pkg::MAX_CHANNELS-1:0]   read_hit,
    input  logic [idb_pkg::MAX_CHANNELS-1:0]   cur_levels,
    input  logic [idb_pkg::MAX_CHANNELS-1:0]   cur_events,
    input  logic [idb_pkg::MAX_CHANNELS-1:0]   next_levels,
    input  logic [idb_pkg::MAX_CHANNELS-1:0]   next_events,
    output logic                               in_ready,
    output logic                               out_valid,
    input  logic                               out_ready,
    output idb_pkg::out_word_t                 out_word
);
    import idb_pkg::*;

    out_word_t out_word_reg;
    out_word_t out_word_next;
    logic      out_valid_reg;

    // New word may enter when the output slot is empty or being drained
    assign in_ready = !out_valid_reg || out_ready;

    // Assemble result word; read picks the addressed lane's pre-clear state
    always_comb
    begin
        out_word_next.stable_levels  = next_levels;
        out_word_next.pending_events = next_events;
        out_word_next.read_level     = is_read && |(cur_levels & read_hit);
        out_word_next.read_event     = is_read && |(cur_events & read_hit);
    end

    // Output valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (capture)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (capture)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

>>> rtl/integrating_debouncer_bank_top.sv
// A result word appears in the cycle after its input word is taken.
// One word per cycle while in_ready is high; every channel lane updates in the same cycle.
// in_ready drops only while the output register is full and out_ready is low.
// Reset: asynchronous, active low; levels, counters and flags clear to zero,
// the settle threshold returns to 20 and the output register is emptied.
// ----------------------------------------------------------------------------
// Integrating debouncer bank
// Switch and button channels debounced by parallel up/down counter lanes.
// ----------------------------------------------------------------------------
module integrating_debouncer_bank_top
#(
    parameter int SWITCH_COUNT = 12,
    parameter int BUTTON_COUNT = 3
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write_en,
    input  logic [idb_pkg::THRESH_W-1:0]      cfg_write_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  idb_pkg::in_word_t                 in_word,
    output logic                              out_valid,
    input  logic                              out_ready,
    output idb_pkg::out_word_t                out_word
);
    import idb_pkg::*;

    localparam int BANK_SIZE = ((SWITCH_COUNT + BUTTON_COUNT) > MAX_CHANNELS) ?
                               MAX_CHANNELS : (SWITCH_COUNT + BUTTON_COUNT);
    localparam logic [MAX_CHANNELS-1:0] BANK_MASK =
        MAX_CHANNELS'((32'd1 << BANK_SIZE) - 32'd1);

    logic [THRESH_W-1:0]     threshold_reg;
    logic                    in_accept;
    lane_ctrl_t              lane_ctrl;
    logic                    read_op;
    logic [MAX_CHANNELS-1:0] read_hit;
    logic [MAX_CHANNELS-1:0] cur_levels;
    logic [MAX_CHANNELS-1:0] cur_events;
    logic [MAX_CHANNELS-1:0] next_levels;
    logic [MAX_CHANNELS-1:0] next_events;

    // Settle threshold register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            threshold_reg <= THRESH_RESET;
        else if (cfg_write_en)
            threshold_reg <= cfg_write_data;
    end

    assign in_accept = in_valid && in_ready;

    // Operation decode
    always_comb
    begin
        lane_ctrl = '0;
        read_op   = 1'b0;
        unique case (in_word.operation)
            OP_TICK: lane_ctrl.tick = in_accept;
            OP_READ: read_op        = in_accept;
            OP_LOAD: lane_ctrl.load = in_accept;
            default: ;
        endcase
    end

    // Channel lanes; positions past the bank hold zero
    for (genvar i = 0; i < MAX_CHANNELS; i++)
    begin : g_lane
        if (i < BANK_SIZE)
        begin : g_used
            assign read_hit[i] = (in_word.channel == CH_IDX_W'(i));

            idb_lane u_lane
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (lane_ctrl),
                .read_clr   (read_op && read_hit[i]),
                .raw_bit    (in_word.raw_levels[i]),
                .threshold  (threshold_reg),
                .level      (cur_levels[i]),
                .event_flag (cur_events[i]),
                .level_next (next_levels[i]),
                .event_next (next_events[i])
            );
        end
        else
        begin : g_unused
            assign read_hit[i]    = 1'b0;
            assign cur_levels[i]  = 1'b0;
            assign cur_events[i]  = 1'b0;
            assign next_levels[i] = 1'b0;
            assign next_events[i] = 1'b0;
        end
    end

    // Merge lanes into the result word
    idb_merge u_merge
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .capture     (in_accept),
        .is_read     (read_op),
        .read_hit    (read_hit),
        .cur_levels  (cur_levels),
        .cur_events  (cur_events),
        .next_levels (next_levels),
        .next_events (next_events),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_word    (out_word)
    );

`ifndef SYNTHESIS
    // Every accepted word yields a result in the following cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid)
        else $error("no result after accepted word");

    // A load leaves no pending events
    a_load_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_word.operation == OP_LOAD) |=> (out_word.pending_events == '0))
        else $error("events remain after load");

    // Reads past the bank return zeros
    a_read_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_word.operation == OP_READ && in_word.channel >= CH_IDX_W'(BANK_SIZE))
        |=> (!out_word.read_level && !out_word.read_event))
        else $error("out-of-range read returned data");

    // Positions past the bank never show a level or event
    a_bank_mask: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (((out_word.stable_levels | out_word.pending_events) & ~BANK_MASK) == '0))
        else $error("level or event outside the bank");
`endif

endmodule
